// ===== design/ascending_integer_sorter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Ascending integer sorter assertion macros
// Shared concurrent assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASCENDING_INTEGER_SORTER_TOP_DEFINES_SVH
`define ASCENDING_INTEGER_SORTER_TOP_DEFINES_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define AIS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sorter assertion failed");
// Expression must never be true outside reset.
`define AIS_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("sorter forbidden condition seen");
`else
`define AIS_ASSERT(label, prop)
`define AIS_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== design/ais_pkg.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter package
// Widths, defaults and the control bundle shared by the sorter cells.
// ----------------------------------------------------------------------------
package ais_pkg;

    localparam int VALUE_W      = 32;
    localparam int CAPACITY_DEF = 64;

    // Control broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic                      insert;
        logic                      shift;
        logic signed [VALUE_W-1:0] value;
    } ais_ctl_t;

endpackage

// ===== design/ais_cell.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter cell
// One slot of the sorted chain: insertion with neighbor handoff, and shift.
// ----------------------------------------------------------------------------
module ais_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ais_pkg::ais_ctl_t                   ctl_i,
    input  logic                                prev_valid_i,
    input  logic                                prev_gt_i,
    input  logic signed [ais_pkg::VALUE_W-1:0]  prev_value_i,
    input  logic                                next_valid_i,
    input  logic signed [ais_pkg::VALUE_W-1:0]  next_value_i,
    output logic                                valid_o,
    output logic                                gt_o,
    output logic signed [ais_pkg::VALUE_W-1:0]  value_o
);
    import ais_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      take;

    // The held value is larger than the incoming one, so it moves up a slot.
    assign gt_o = valid_reg && (value_reg > ctl_i.value);
    // An empty slot right above the last full one takes the new tail.
    assign take = gt_o || (!valid_reg && prev_valid_i);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctl_i.shift) begin
            valid_next = next_valid_i;
            value_next = next_value_i;
        end else if (ctl_i.insert && take) begin
            valid_next = 1'b1;
            value_next = prev_gt_i ? prev_value_i : ctl_i.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid_o = valid_reg;
    assign value_o = value_reg;

endmodule

// ===== design/ascending_integer_sorter_top.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter
// Systolic insertion sorter for sets of signed 32-bit values.
// ----------------------------------------------------------------------------
// The sorter collects a set of signed 32-bit values, one per input beat, until
// a beat with s_axis_tlast high arrives, and then returns the held values in
// ascending order, one per output beat, with m_axis_tlast on the largest and
// final one. It is built as a chain of CAPACITY cells that always holds its
// contents sorted: on each accepted beat every cell compares the new value
// with its own, and the larger values move up one cell while the new value
// drops into its place, so an input beat is taken in every cycle while the
// set is collected. After the last beat the chain shifts down toward cell 0,
// which drives the output, one result per cycle while m_axis_tready is high.
// The input is not ready while the chain drains. Values beyond CAPACITY are
// dropped and every result of that set then carries the overflow flag in
// m_axis_tuser. The chain is empty after reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ascending_integer_sorter_top #(
    parameter int CAPACITY = ais_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input channel.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ais_pkg::VALUE_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic                        s_axis_tlast,   // last value of the set
    // Result channel.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ais_pkg::VALUE_W-1:0] m_axis_tdata,   // [31:0] sorted_value
    output logic                        m_axis_tlast,   // end_of_set
    output logic [0:0]                  m_axis_tuser    // [0] overflowed
);
    import ais_pkg::*;

    `include "ascending_integer_sorter_top_defines.svh"

    // Sequencer states: collecting a set, or draining it out.
    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic                      overflow_reg;
    logic                      overflow_next;

    logic                      in_beat;
    logic                      out_beat;
    logic                      full;
    ais_ctl_t                  ctl;

    logic [CAPACITY-1:0]       valid_vec;
    logic [CAPACITY-1:0]       gt_vec;
    logic signed [VALUE_W-1:0] value_arr [CAPACITY];

    assign s_axis_tready = (state_reg == ST_FILL);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_DRAIN);
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    // The chain fills from cell 0 up, so the top cell tells when it is full.
    assign full = valid_vec[CAPACITY-1];

    assign ctl.insert = in_beat && !full;
    assign ctl.shift  = out_beat;
    assign ctl.value  = $signed(s_axis_tdata);

    always_comb begin
        state_next    = state_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_FILL: begin
                if (in_beat) begin
                    if (full) begin
                        overflow_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // The final result leaves when only cell 0 still holds a value.
                if (out_beat && !valid_vec[1]) begin
                    state_next    = ST_FILL;
                    overflow_next = 1'b0;
                end
            end
            default: begin
                state_next    = ST_FILL;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            overflow_reg <= overflow_next;
        end
    end

    // The chain of cells. Cell 0 holds the smallest value and sees a virtual
    // neighbor below it that is valid and never larger; the top cell sees an
    // empty neighbor above it when the chain shifts down.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      prev_valid;
        logic                      prev_gt;
        logic signed [VALUE_W-1:0] prev_value;
        logic                      next_valid;
        logic signed [VALUE_W-1:0] next_value;

        if (i == 0) begin : g_bottom
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
            assign prev_value = ctl.value;
        end else begin : g_inner_lo
            assign prev_valid = valid_vec[i-1];
            assign prev_gt    = gt_vec[i-1];
            assign prev_value = value_arr[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign next_valid = 1'b0;
            assign next_value = value_arr[i];
        end else begin : g_inner_hi
            assign next_valid = valid_vec[i+1];
            assign next_value = value_arr[i+1];
        end

        ais_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl_i        (ctl),
            .prev_valid_i (prev_valid),
            .prev_gt_i    (prev_gt),
            .prev_value_i (prev_value),
            .next_valid_i (next_valid),
            .next_value_i (next_value),
            .valid_o      (valid_vec[i]),
            .gt_o         (gt_vec[i]),
            .value_o      (value_arr[i])
        );
    end

    // Cell 0 is the output register of the result channel.
    assign m_axis_tdata    = value_arr[0];
    assign m_axis_tlast    = !valid_vec[1];
    assign m_axis_tuser[0] = overflow_reg;

    // Occupied cells always form one block starting at cell 0.
    `AIS_ASSERT_NEVER(a_valid_contiguous, (valid_vec & (valid_vec + CAPACITY'(1))) != '0)
    // While draining, cell 0 always holds a result.
    `AIS_ASSERT(a_drain_nonempty, (state_reg == ST_DRAIN) |-> valid_vec[0])
    // A result that is not the final one is followed by another result.
    `AIS_ASSERT(a_drain_continues, (out_beat && !m_axis_tlast) |=> m_axis_tvalid)
    // A beat that finds the chain full marks the set as overflowed.
    `AIS_ASSERT(a_overflow_flag, (in_beat && full) |=> overflow_reg)

endmodule

// ===== bench/ascending_integer_sorter_top_test.sv =====
// ----------------------------------------------------------------------------
// Ascending integer sorter testbench
// Streams sets of signed values into the sorter under random flow control and
// checks every result beat against a sorted copy of the set.
// ----------------------------------------------------------------------------
// A scoreboard object records each accepted input beat. When a beat marked
// last is accepted, it sorts the values of the set and queues one expected
// result per held value. Values beyond the capacity are dropped and flag the
// whole set as overflowed. A monitor compares every accepted result beat with
// the oldest expectation. Stimulus starts with short directed sets (extreme
// values, duplicates, reversed order, single values). A phase with a long
// receiver stall follows, then sets that fill and overflow the store, then
// random sets. Both sides idle in random bursts, except in the final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ascending_integer_sorter_top_test;

    localparam int          CAPACITY    = ais_pkg::CAPACITY_DEF;
    localparam int          ITEM_TARGET = 300;
    localparam int          CALM_ITEMS  = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_TAIL  = 2 * CAPACITY;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          REPORT_MAX  = 10;
    localparam logic [31:0] MIN_VALUE   = 32'h8000_0000;
    localparam logic [31:0] MAX_VALUE   = 32'h7FFF_FFFF;

    // One result beat as the sorter should produce it.
    typedef struct packed {
        logic signed [31:0] value;
        logic               end_of_set;
        logic               overflowed;
    } sorted_beat_t;

    // Predicts the sorted output of each set and checks result beats in order.
    class sort_scoreboard;
        logic signed [31:0] held_values[$];
        bit                 overflow_seen;
        sorted_beat_t       expected_beats[$];
        int                 mismatches;

        // Records one accepted input beat; on the last one queues the sorted set.
        function void note_input(input logic [31:0] raw, input logic is_last);
            logic signed [31:0] key;
            int                 i;
            int                 j;
            sorted_beat_t       beat;
            if (held_values.size() < CAPACITY) begin
                held_values.push_back(raw);
            end else begin
                overflow_seen = 1'b1;
            end
            if (!is_last) return;
            // Plain insertion sort; the sets are small.
            for (i = 1; i < held_values.size(); i++) begin
                key = held_values[i];
                j   = i;
                while (j > 0 && held_values[j-1] > key) begin
                    held_values[j] = held_values[j-1];
                    j--;
                end
                held_values[j] = key;
            end
            for (i = 0; i < held_values.size(); i++) begin
                beat.value      = held_values[i];
                beat.end_of_set = (i == held_values.size() - 1);
                beat.overflowed = overflow_seen;
                expected_beats.push_back(beat);
            end
            held_values.delete();
            overflow_seen = 1'b0;
        endfunction

        // Compares one accepted result beat with the oldest expectation.
        function void check_result(input logic [31:0] value, input logic end_of_set,
                                   input logic overflowed);
            sorted_beat_t got;
            sorted_beat_t want;
            got.value      = value;
            got.end_of_set = end_of_set;
            got.overflowed = overflowed;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected result beat: value %0d last %b overflow %b",
                             $time, got.value, got.end_of_set, got.overflowed);
                return;
            end
            want = expected_beats.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] expected value %0d last %b overflow %b, got %0d %b %b",
                             $time, want.value, want.end_of_set, want.overflowed,
                             got.value, got.end_of_set, got.overflowed);
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] value
    logic        s_axis_tlast  = 1'b0;  // last value of the set
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] sorted_value
    logic        m_axis_tlast;          // end_of_set
    logic [0:0]  m_axis_tuser;          // [0] overflowed

    sort_scoreboard board;
    int             items_sent    = 0;
    int             cycle_count   = 0;
    int             feed_idle_pct = 0;
    int             sink_idle_pct = 0;
    bit             calm          = 1'b0;
    bit             hold_request  = 1'b0;

    ascending_integer_sorter_top #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Hard stop in case the sorter hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result monitor: a beat counts when tvalid and tready are both high.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!calm && sink_idle_pct != 0 &&
                         $urandom_range(1, 100) <= sink_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Mostly full-range values, with a share of extremes and a narrow band
    // around zero so that duplicates and sign changes are common.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return MIN_VALUE;
                    1: return MAX_VALUE;
                    2: return MIN_VALUE + 32'd1;
                    3: return MAX_VALUE - 32'd1;
                    4: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
            1, 2: return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // Offers one beat, possibly after an idle burst, and waits for acceptance.
    task automatic feed_beat(input logic [31:0] value, input logic is_last);
        if (!calm && feed_idle_pct != 0 && $urandom_range(1, 100) <= feed_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_input(value, is_last);
        items_sent++;
        if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
    endtask

    // Sends a set of random values with fresh idle rates on both sides.
    task automatic feed_set(input int count);
        case ($urandom_range(0, 2))
            0: feed_idle_pct = 0;
            1: feed_idle_pct = 10;
            default: feed_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
            0: sink_idle_pct = 0;
            1: sink_idle_pct = 10;
            default: sink_idle_pct = 35;
        endcase
        for (int n = 0; n < count; n++) feed_beat(pick_value(), n == count - 1);
    endtask

    // Holds the input idle until every expected result beat has arrived.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-value sets at both ends of the range.
        feed_beat(MIN_VALUE, 1'b1);
        feed_beat(MAX_VALUE, 1'b1);
        // Extremes, duplicates and sign boundaries out of order.
        feed_beat(MAX_VALUE,    1'b0);
        feed_beat(MIN_VALUE,    1'b0);
        feed_beat(32'd0,        1'b0);
        feed_beat(32'hFFFF_FFFF, 1'b0);
        feed_beat(32'd1,        1'b0);
        feed_beat(MAX_VALUE,    1'b0);
        feed_beat(MIN_VALUE,    1'b1);
        // Strictly descending input, the worst case for an insertion sort.
        feed_beat(32'd5, 1'b0);
        feed_beat(32'd4, 1'b0);
        feed_beat(32'd3, 1'b0);
        feed_beat(32'd2, 1'b0);
        feed_beat(32'd1, 1'b1);
        // Two equal values.
        feed_beat(32'd0, 1'b0);
        feed_beat(32'd0, 1'b1);
        // Already ascending across zero.
        feed_beat(32'hFFFF_FFFE, 1'b0);
        feed_beat(32'hFFFF_FFFF, 1'b0);
        feed_beat(32'd0,         1'b0);
        feed_beat(32'd1,         1'b1);

        // Long receiver hold-off: a full set drains into a stalled output, and
        // the next set backs up against the input while the chain is busy.
        hold_request = 1'b1;
        feed_set(CAPACITY);
        feed_set(6);
        wait_results_drained();

        // Overflow: first only the last beat finds the store full, then
        // several beats are dropped before it.
        feed_set(CAPACITY + 1);
        feed_set(CAPACITY + 5);
        feed_set(CAPACITY - 1);

        while (items_sent < ITEM_TARGET) begin
            feed_set($urandom_range(1, 12));
            if ($urandom_range(0, 5) == 0) wait_results_drained();
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ais_pkg.sv
design/ais_cell.sv
design/ascending_integer_sorter_top.sv
bench/ascending_integer_sorter_top_test.sv
